[src/hftf_pkg.sv]
// Shared types, codes and helpers for the handle table with lowest-free allocation.
`default_nettype none
package hftf_pkg;

    localparam int SLOTS_DEF    = 64;
    localparam int REF_BITS_DEF = 32;

    localparam int OP_W       = 3;
    localparam int IDX_W      = 6;
    localparam int OREF_W     = 32;
    localparam int ST_W       = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // free-slot search works on groups of used bits
    localparam int GRP_W   = 32;
    localparam int GRP_LOG = 5;

    localparam int QDEPTH = 2;
    localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_INSERT  = 3'd1,
        OP_REPLACE = 3'd2,
        OP_GET     = 3'd3,
        OP_REMOVE  = 3'd4
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_OCCUPIED = 3'd3,
        ST_ZERO     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_ALLOC,
        CMD_INSERT,
        CMD_REPLACE,
        CMD_GET,
        CMD_REMOVE
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } t_bk_state;

    // classified item as it travels from front to back
    typedef struct packed {
        t_cmd              cmd;
        t_status           status;
        logic [IDX_W-1:0]  idx;
        logic [OREF_W-1:0] oref;
    } t_entry;

    // position of the lowest clear bit; only meaningful when one is clear
    function automatic logic [GRP_LOG-1:0] lowest_zero(input logic [GRP_W-1:0] w);
        logic [GRP_LOG-1:0] pos;
        pos = '0;
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = GRP_LOG'(i);
            end
        end
        return pos;
    endfunction

endpackage
`default_nettype wire

[src/hftf_front.sv]
// Input side: decodes an item, runs range and zero-reference checks, hands it to the queue.
`default_nettype none
module hftf_front
    import hftf_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int REF_BITS = REF_BITS_DEF
) (
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,  // slot_index[5:0], object_ref[37:6], pad
    input  wire logic [OP_W-1:0]      s_axis_tuser,  // opcode[2:0]
    input  wire logic                 i_q_full,
    output logic                      o_q_push,
    output t_entry                    o_q_entry
);

    localparam logic [63:0] REF_MASK = {64{1'b1}} >> (64 - REF_BITS);

    logic [IDX_W-1:0]  w_idx;
    logic [OREF_W-1:0] w_oref;
    logic              w_in_range;
    logic              w_ref_zero;

    assign w_idx      = s_axis_tdata[IDX_W-1:0];
    assign w_oref     = s_axis_tdata[IDX_W +: OREF_W] & REF_MASK[OREF_W-1:0];
    assign w_in_range = 32'(w_idx) < 32'(SLOTS);
    assign w_ref_zero = (w_oref == '0);

    assign s_axis_tready = !i_q_full;
    assign o_q_push      = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_q_entry        = '0;
        o_q_entry.cmd    = CMD_NOP;
        o_q_entry.status = ST_OK;
        o_q_entry.idx    = w_idx;
        o_q_entry.oref   = w_oref;
        unique case (s_axis_tuser)
            OP_ALLOC: begin
                if (w_ref_zero) begin
                    o_q_entry.status = ST_ZERO;
                    o_q_entry.idx    = '0;   // refused alloc reports handle 0
                end else begin
                    o_q_entry.cmd = CMD_ALLOC;
                end
            end
            OP_INSERT, OP_REPLACE: begin
                if (!w_in_range) begin
                    o_q_entry.status = ST_RANGE;
                end else if (w_ref_zero) begin
                    o_q_entry.status = ST_ZERO;
                end else begin
                    o_q_entry.cmd = (s_axis_tuser == OP_INSERT) ? CMD_INSERT : CMD_REPLACE;
                end
            end
            OP_GET, OP_REMOVE: begin
                if (!w_in_range) begin
                    o_q_entry.status = ST_RANGE;
                end else begin
                    o_q_entry.cmd = (s_axis_tuser == OP_GET) ? CMD_GET : CMD_REMOVE;
                end
            end
            default: begin
                o_q_entry.cmd = CMD_NOP;
            end
        endcase
    end

endmodule
`default_nettype wire

[src/hftf_queue.sv]
// Short FIFO of classified items between front and back.
`default_nettype none
module hftf_queue
    import hftf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output logic        o_empty
);

    t_entry           r_mem [QDEPTH];
    logic [QPW-1:0]   r_wptr, n_wptr;
    logic [QPW-1:0]   r_rptr, n_rptr;
    logic [QPW:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QPW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == QPW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

[src/hftf_back.sv]
// Execution side: reference store, used bits, lowest-free search and result register.
`default_nettype none
module hftf_back
    import hftf_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int REF_BITS = REF_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_empty,
    input  wire t_entry                i_q_head,
    output logic                       o_q_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata  // handle_out[5:0], previous_ref[37:6],
                                                     // status[40:38], pad
);

    localparam int SW   = $clog2(SLOTS);
    localparam int NGRP = (SLOTS + GRP_W - 1) / GRP_W;
    localparam int GBW  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PADW = NGRP * GRP_W;

    t_bk_state             r_state, n_state;
    logic [SLOTS-1:0]      r_used;
    t_entry                r_cur;
    logic [REF_BITS-1:0]   r_rdata;
    logic [NGRP-1:0]       r_grp_free;
    logic [GRP_LOG-1:0]    r_grp_low [NGRP];
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [REF_BITS-1:0]   mem [SLOTS];

    logic [PADW-1:0]       w_used_pad;
    logic [SW-1:0]         w_head_addr;
    logic [SW-1:0]         w_cur_addr;
    logic                  w_cur_used;
    logic [OREF_W-1:0]     w_prev_ref;
    logic                  w_any_free;
    logic [GBW-1:0]        w_sel_grp;
    logic [GRP_LOG-1:0]    w_sel_low;
    logic [SW-1:0]         w_alloc_addr;
    logic                  w_issue;
    logic                  w_exec;
    logic                  w_we;
    logic                  w_clr;
    logic [SW-1:0]         w_waddr;
    logic [IDX_W-1:0]      w_handle;
    logic [OREF_W-1:0]     w_prev;
    t_status               w_status;

    // slots past the end of the table count as used
    for (genvar k = 0; k < PADW; k++) begin : g_pad
        if (k < SLOTS) begin : g_real
            assign w_used_pad[k] = r_used[k];
        end else begin : g_fill
            assign w_used_pad[k] = 1'b1;
        end
    end

    assign w_head_addr = SW'(i_q_head.idx);
    assign w_cur_addr  = SW'(r_cur.idx);
    assign w_cur_used  = r_used[w_cur_addr];
    // never-written entries are masked by their used bit
    assign w_prev_ref  = w_cur_used ? OREF_W'(r_rdata) : '0;

    // second level of the free search over the registered group summaries
    always_comb begin
        w_any_free = 1'b0;
        w_sel_grp  = '0;
        w_sel_low  = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                w_any_free = 1'b1;
                w_sel_grp  = GBW'(g);
                w_sel_low  = r_grp_low[g];
            end
        end
    end
    assign w_alloc_addr = SW'({w_sel_grp, w_sel_low});

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb begin
        w_issue = 1'b0;
        w_exec  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                w_issue = !i_q_empty;
            end
            BK_EXEC: begin
                w_exec = !r_out_valid || m_axis_tready;
            end
            default: begin
                w_issue = 1'b0;
            end
        endcase
    end
    assign o_q_pop = w_issue;

    // result and store update for the item in execution
    always_comb begin
        w_handle = r_cur.idx;
        w_prev   = '0;
        w_status = r_cur.status;
        w_we     = 1'b0;
        w_clr    = 1'b0;
        w_waddr  = w_cur_addr;
        unique case (r_cur.cmd)
            CMD_ALLOC: begin
                w_handle = '0;
                if (w_any_free) begin
                    w_we     = 1'b1;
                    w_waddr  = w_alloc_addr;
                    w_handle = IDX_W'(w_alloc_addr);
                end else begin
                    w_status = ST_FULL;
                end
            end
            CMD_INSERT: begin
                if (w_cur_used) begin
                    w_status = ST_OCCUPIED;
                end else begin
                    w_we = 1'b1;
                end
            end
            CMD_REPLACE: begin
                w_prev = w_prev_ref;
                w_we   = 1'b1;
            end
            CMD_GET: begin
                w_prev = w_prev_ref;
            end
            CMD_REMOVE: begin
                w_prev = w_prev_ref;
                w_clr  = 1'b1;
            end
            default: begin
                w_prev = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec && w_we) begin
                r_used[w_waddr] <= 1'b1;
            end
            if (w_exec && w_clr) begin
                r_used[w_cur_addr] <= 1'b0;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_cur <= i_q_head;
            for (int g = 0; g < NGRP; g++) begin
                r_grp_free[g] <= ~&w_used_pad[g*GRP_W +: GRP_W];
                r_grp_low[g]  <= lowest_zero(w_used_pad[g*GRP_W +: GRP_W]);
            end
        end
        if (w_exec) begin
            r_out_data <= {(OUT_DATA_W - ST_W - OREF_W - IDX_W)'(0), w_status, w_prev, w_handle};
        end
    end

    // reference store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_exec && w_we) begin
            mem[w_waddr] <= REF_BITS'(r_cur.oref);
        end
        if (w_issue) begin
            r_rdata <= mem[w_head_addr];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

[src/handle_table_first_free.sv]
// Top level of the handle table with lowest-free allocation.
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | tuser: opcode; tdata: slot_index, object_ref
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata: handle_out, previous_ref, status
//
// Each item passes through back-end states IDLE and EXEC: IDLE reads its slot
// from the reference store and registers the per-group free summaries; EXEC
// resolves the lowest free slot, writes the store and loads the result register.
// The back end finishes one item before it takes the next from the queue.
// Reset clears the used bits; the store itself is not swept, an
// entry whose used bit is clear reads as empty.
// A 2-entry queue sits between decode and execution, so input stays open while a
// result waits for m_axis_tready until the queue fills; a stalled output holds
// execution in place.
`default_nettype none
module handle_table_first_free
    import hftf_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,    // table depth, 2 to 64
    parameter int REF_BITS = REF_BITS_DEF  // stored reference width, 8 to 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // slot_index[5:0], object_ref[37:6],
                                                      // zero pad[39:38]
    input  wire logic [OP_W-1:0]       s_axis_tuser,  // opcode[2:0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata   // handle_out[5:0], previous_ref[37:6],
                                                      // status[40:38], zero pad[47:41]
);

    logic   w_q_full;
    logic   w_q_push;
    t_entry w_q_entry;
    logic   w_q_pop;
    t_entry w_q_head;
    logic   w_q_empty;

    // decode and early checks
    hftf_front #(
        .SLOTS    (SLOTS),
        .REF_BITS (REF_BITS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_entry     (w_q_entry)
    );

    hftf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_entry (w_q_entry),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_head  (w_q_head),
        .o_empty (w_q_empty)
    );

    // store, allocation search and result register
    hftf_back #(
        .SLOTS    (SLOTS),
        .REF_BITS (REF_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_head      (w_q_head),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

[src/hftf_chk.sv]
// Port-level checks for the handle table, bound to the top level.
`default_nettype none
module hftf_chk
    import hftf_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [IDX_W-1:0]  w_handle;
    logic [OREF_W-1:0] w_prev;
    logic [ST_W-1:0]   w_status;

    assign w_handle = m_axis_tdata[IDX_W-1:0];
    assign w_prev   = m_axis_tdata[IDX_W +: OREF_W];
    assign w_status = m_axis_tdata[IDX_W + OREF_W +: ST_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_status == ST_OK || w_status == ST_FULL || w_status == ST_RANGE
                           || w_status == ST_OCCUPIED || w_status == ST_ZERO)
                          && m_axis_tdata[OUT_DATA_W-1:IDX_W + OREF_W + ST_W] == '0)
        else $error("bad status code or pad bits");

    a_error_no_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status != ST_OK |-> w_prev == '0)
        else $error("refused item returned a reference");

    a_full_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status == ST_FULL |-> w_handle == '0)
        else $error("full table returned a nonzero handle");

endmodule

bind handle_table_first_free hftf_chk u_hftf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
